// ----- src/assert_macros.svh -----
// Assertion macros used by the decoder back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset.
`define U8SD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define U8SD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/u8sd_pkg.sv -----
// Types and constants shared by the UTF-8 stream decoder.
package u8sd_pkg;

	localparam int unsigned DEF_MAX_STRING_BYTES = 65536;
	localparam int unsigned DEF_QUEUE_DEPTH = 2;

	localparam logic [7:0] ASCII_MASK = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_TAG = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_TAG = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_TAG = 8'hF0;

	localparam logic [20:0] REPLACEMENT_POINT = 21'd63;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		CLS_ZERO,
		CLS_ASCII,
		CLS_LEAD2,
		CLS_LEAD3,
		CLS_LEAD4,
		CLS_OTHER
	} cls_t;

	typedef struct packed {
		cls_t cls;
		logic [7:0] data;
	} op_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic [2:0] char_len;
		logic [15:0] char_start;
		logic [15:0] char_number;
		logic is_end;
		logic bad_lead;
		logic truncated;
		logic [15:0] final_char_start;
	} res_t;

endpackage

// ----- src/u8sd_channels.sv -----
// Valid/ready channel interfaces for the decoder's byte input and result output.
interface u8sd_byte_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface u8sd_result_if import u8sd_pkg::*;;
	logic valid;
	logic ready;
	res_t result;

	modport source (output valid, output result, input ready);
	modport sink (input valid, input result, output ready);
endinterface

// ----- src/utf8_stream_decoder_unit.sv -----
// Top level of the UTF-8 stream decoder: front end, request queue and back end.
//
// The in_ch channel takes one byte of a zero-terminated UTF-8 string per request.
// The out_ch channel delivers one result per completed character or invalid lead
// byte, and one end result for each zero byte, with the character count and the
// last start offset. Valid lead bytes and continuation bytes that complete no
// character give no result. Throughput is one byte per cycle while the result
// register is free or being taken: the front end classifies a byte in the cycle it
// is accepted and writes it to a two-entry queue, and the back end consumes one
// queued byte per cycle with a single register update of its state and result.
// When the receiver stalls, the result register holds its request and the queue
// fills; in_ch drops ready only once the queue is full, and bytes that produce
// no result keep draining only while the result register is free or being taken.
// Reset clears the decoder state, the queue and the result valid flag; the block
// can accept a byte in the first cycle after arst_n is released.
module utf8_stream_decoder_unit import u8sd_pkg::*; #(
	parameter int unsigned MAX_STRING_BYTES = DEF_MAX_STRING_BYTES,
	parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	u8sd_byte_if.sink in_ch,
	u8sd_result_if.source out_ch
);

	logic push_valid;
	op_t push_op;
	logic push_ready;
	logic q_valid;
	op_t q_op;
	logic q_ready;

	u8sd_front u_front (
		.in_ch(in_ch),
		.push_valid(push_valid),
		.push_op(push_op),
		.push_ready(push_ready)
	);

	u8sd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_op(push_op),
		.push_ready(push_ready),
		.pop_valid(q_valid),
		.pop_op(q_op),
		.pop_ready(q_ready)
	);

	u8sd_back #(
		.MAX_STRING_BYTES(MAX_STRING_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_op(q_op),
		.q_ready(q_ready),
		.out_ch(out_ch)
	);

endmodule

// ----- src/u8sd_front.sv -----
// Front end: accepts input bytes and classifies each one by its lead pattern.
module u8sd_front import u8sd_pkg::*; (
	u8sd_byte_if.sink in_ch,
	output logic push_valid,
	output op_t push_op,
	input logic push_ready
);

	cls_t cls;

	always_comb begin
		if (in_ch.data_byte == 8'd0) begin
			cls = CLS_ZERO;
		end else if ((in_ch.data_byte & ASCII_MASK) == 8'd0) begin
			cls = CLS_ASCII;
		end else if ((in_ch.data_byte & LEAD2_MASK) == LEAD2_TAG) begin
			cls = CLS_LEAD2;
		end else if ((in_ch.data_byte & LEAD3_MASK) == LEAD3_TAG) begin
			cls = CLS_LEAD3;
		end else if ((in_ch.data_byte & LEAD4_MASK) == LEAD4_TAG) begin
			cls = CLS_LEAD4;
		end else begin
			cls = CLS_OTHER;
		end
	end

	assign push_valid = in_ch.valid;
	assign push_op = '{cls: cls, data: in_ch.data_byte};
	assign in_ch.ready = push_ready;

endmodule

// ----- src/u8sd_queue.sv -----
// Short first-in first-out queue of classified requests between front and back.
module u8sd_queue import u8sd_pkg::*; #(
	parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	input op_t push_op,
	output logic push_ready,
	output logic pop_valid,
	output op_t pop_op,
	input logic pop_ready
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	op_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_op = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/u8sd_back.sv -----
// Back end: holds the decoder state, assembles characters and registers results.
`include "assert_macros.svh"

module u8sd_back import u8sd_pkg::*; #(
	parameter int unsigned MAX_STRING_BYTES = DEF_MAX_STRING_BYTES
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input op_t q_op,
	output logic q_ready,
	u8sd_result_if.source out_ch
);

	localparam int unsigned POS_LIMIT_INT =
		(MAX_STRING_BYTES - 1 > 65535) ? 65535 : MAX_STRING_BYTES - 1;
	localparam logic [15:0] POS_LIMIT = 16'(POS_LIMIT_INT);

	logic [1:0] pend_q;
	logic [2:0] len_q;
	logic [20:0] acc_q;
	logic [15:0] chars_q;
	logic [15:0] pos_q;
	logic [15:0] cur_q;
	logic [15:0] prev_q;
	logic out_valid_q;
	res_t res_q;

	logic [1:0] pend_d;
	logic [2:0] len_d;
	logic [20:0] acc_d;
	logic [15:0] chars_d;
	logic [15:0] pos_d;
	logic [15:0] cur_d;
	logic [15:0] prev_d;
	logic has_res;
	res_t res_d;

	logic pop;
	logic [15:0] chars_inc;
	logic [15:0] pos_inc;
	logic [20:0] acc_shift;
	logic [1:0] pend_dec;

	assign pop = q_valid && (!out_valid_q || out_ch.ready);
	assign q_ready = pop;
	assign chars_inc = (chars_q != COUNT_MAX) ? chars_q + 16'd1 : chars_q;
	assign pos_inc = (pos_q < POS_LIMIT) ? pos_q + 16'd1 : pos_q;
	assign acc_shift = {acc_q[14:0], q_op.data[5:0]};
	assign pend_dec = pend_q - 2'd1;

	always_comb begin
		pend_d = pend_q;
		len_d = len_q;
		acc_d = acc_q;
		chars_d = chars_q;
		pos_d = pos_inc;
		cur_d = cur_q;
		prev_d = prev_q;
		has_res = 1'b0;
		res_d = '0;
		if (q_op.cls == CLS_ZERO) begin
			has_res = 1'b1;
			res_d.is_end = 1'b1;
			if (pend_q != 2'd0) begin
				res_d.code_point = REPLACEMENT_POINT;
				res_d.char_len = len_q - {1'b0, pend_q};
				res_d.char_start = cur_q;
				res_d.char_number = chars_inc;
				res_d.truncated = 1'b1;
				res_d.final_char_start = cur_q;
			end else begin
				res_d.char_start = pos_q;
				res_d.char_number = chars_q;
				res_d.final_char_start = prev_q;
			end
			pend_d = '0;
			len_d = '0;
			acc_d = '0;
			chars_d = '0;
			pos_d = '0;
			cur_d = '0;
			prev_d = '0;
		end else if (pend_q != 2'd0) begin
			acc_d = acc_shift;
			pend_d = pend_dec;
			if (pend_dec == 2'd0) begin
				has_res = 1'b1;
				res_d.code_point = acc_shift;
				res_d.char_len = len_q;
				res_d.char_start = cur_q;
				res_d.char_number = chars_q;
				chars_d = chars_inc;
				prev_d = cur_q;
			end
		end else begin
			cur_d = pos_q;
			res_d.char_start = pos_q;
			res_d.char_number = chars_q;
			unique case (q_op.cls)
				CLS_ASCII: begin
					has_res = 1'b1;
					res_d.code_point = {14'd0, q_op.data[6:0]};
					res_d.char_len = 3'd1;
					chars_d = chars_inc;
					prev_d = pos_q;
				end
				CLS_LEAD2: begin
					acc_d = {16'd0, q_op.data[4:0]};
					len_d = 3'd2;
					pend_d = 2'd1;
				end
				CLS_LEAD3: begin
					acc_d = {17'd0, q_op.data[3:0]};
					len_d = 3'd3;
					pend_d = 2'd2;
				end
				CLS_LEAD4: begin
					acc_d = {18'd0, q_op.data[2:0]};
					len_d = 3'd4;
					pend_d = 2'd3;
				end
				default: begin
					has_res = 1'b1;
					res_d.code_point = REPLACEMENT_POINT;
					res_d.char_len = 3'd1;
					res_d.bad_lead = 1'b1;
					chars_d = chars_inc;
					prev_d = pos_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			len_q <= '0;
			acc_q <= '0;
			chars_q <= '0;
			pos_q <= '0;
			cur_q <= '0;
			prev_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pend_q <= pend_d;
				len_q <= len_d;
				acc_q <= acc_d;
				chars_q <= chars_d;
				pos_q <= pos_d;
				cur_q <= cur_d;
				prev_q <= prev_d;
				out_valid_q <= has_res;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.result = res_q;

	`U8SD_ASSERT(a_end_clears_state, pop && q_op.cls == CLS_ZERO |=> pend_q == 2'd0 && chars_q == 16'd0 && pos_q == 16'd0, "terminator did not clear the decoder state")
	`U8SD_ASSERT_ALWAYS(a_pending_below_length, pend_q != 2'd0 |-> len_q > {1'b0, pend_q}, "pending count is not below the sequence length")
	`U8SD_ASSERT(a_truncated_is_end, out_valid_q && res_q.truncated |-> res_q.is_end, "truncated result without end flag")
	`U8SD_ASSERT(a_chars_saturate, pop && q_op.cls != CLS_ZERO && chars_q == COUNT_MAX |=> chars_q == COUNT_MAX, "character count wrapped")

endmodule

// ----- verif/u8sd_decode_checker.sv -----
// Monitor and scoreboard that predicts and checks every result of the UTF-8 stream decoder.
module u8sd_decode_checker import u8sd_pkg::*; #(
	parameter int unsigned MAX_STRING_BYTES = DEF_MAX_STRING_BYTES
) (
	input logic clk,
	input logic arst_n,
	u8sd_byte_if in_mon,
	u8sd_result_if out_mon,
	output int unsigned fail_count,
	output int unsigned waiting,
	output int unsigned results_seen,
	output int unsigned ends_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned POS_LIMIT =
		(MAX_STRING_BYTES - 1 > 65535) ? 65535 : MAX_STRING_BYTES - 1;
	localparam int unsigned REPORT_LIMIT = 40;

	bit [1:0] pend_bytes;
	bit [2:0] seq_len;
	bit [20:0] acc_point;
	bit [15:0] char_count;
	bit [15:0] next_pos;
	bit [15:0] cur_start;
	bit [15:0] last_start;

	res_t expected_q[$];
	int unsigned errors;
	int unsigned n_waiting;
	int unsigned n_results;
	int unsigned n_ends;

	assign fail_count = errors;
	assign waiting = n_waiting;
	assign results_seen = n_results;
	assign ends_seen = n_ends;

	function automatic void clear_decoder();
		pend_bytes = '0;
		seq_len = '0;
		acc_point = '0;
		char_count = '0;
		next_pos = '0;
		cur_start = '0;
		last_start = '0;
	endfunction

	function automatic res_t finish_char(input logic [20:0] cp, input logic [2:0] len,
			input logic bad);
		res_t r;
		r = '0;
		r.code_point = cp;
		r.char_len = len;
		r.char_start = cur_start;
		r.char_number = char_count;
		r.bad_lead = bad;
		if (char_count != COUNT_MAX) begin
			char_count++;
		end
		last_start = cur_start;
		return r;
	endfunction

	function automatic bit decode_byte(input logic [7:0] b, output res_t r);
		bit hit;
		hit = 1'b0;
		r = '0;
		if (b == 8'h00) begin
			r.is_end = 1'b1;
			if (pend_bytes != 0) begin
				r.code_point = REPLACEMENT_POINT;
				r.char_len = seq_len - {1'b0, pend_bytes};
				r.char_start = cur_start;
				r.char_number = (char_count == COUNT_MAX) ? COUNT_MAX : char_count + 16'd1;
				r.truncated = 1'b1;
				r.final_char_start = cur_start;
			end else begin
				r.char_start = next_pos;
				r.char_number = char_count;
				r.final_char_start = last_start;
			end
			clear_decoder();
			return 1'b1;
		end
		if (pend_bytes != 0) begin
			acc_point = {acc_point[14:0], b[5:0]};
			pend_bytes--;
			if (pend_bytes == 0) begin
				r = finish_char(acc_point, seq_len, 1'b0);
				hit = 1'b1;
			end
		end else begin
			cur_start = next_pos;
			if ((b & ASCII_MASK) == 8'h00) begin
				r = finish_char({13'd0, b}, 3'd1, 1'b0);
				hit = 1'b1;
			end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
				acc_point = {16'd0, b[4:0]};
				seq_len = 3'd2;
				pend_bytes = 2'd1;
			end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
				acc_point = {17'd0, b[3:0]};
				seq_len = 3'd3;
				pend_bytes = 2'd2;
			end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
				acc_point = {18'd0, b[2:0]};
				seq_len = 3'd4;
				pend_bytes = 2'd3;
			end else begin
				r = finish_char(REPLACEMENT_POINT, 3'd1, 1'b1);
				hit = 1'b1;
			end
		end
		if (next_pos < POS_LIMIT[15:0]) begin
			next_pos++;
		end
		return hit;
	endfunction

	task automatic check_field(input string name, input logic [20:0] want,
			input logic [20:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= REPORT_LIMIT) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		end
	endtask

	initial begin
		clear_decoder();
		errors = 0;
		n_waiting = 0;
		n_results = 0;
		n_ends = 0;
	end

	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (arst_n) begin
			if (in_mon.valid && in_mon.ready) begin
				if (decode_byte(in_mon.data_byte, want)) begin
					expected_q.push_back(want);
				end
			end
			if (out_mon.valid && out_mon.ready) begin
				got = out_mon.result;
				n_results++;
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT) begin
						$display("%0t: unexpected result, expected none, actual %0h", $time, got);
					end
				end else begin
					want = expected_q.pop_front();
					check_field("code_point", want.code_point, got.code_point);
					check_field("char_len", 21'(want.char_len), 21'(got.char_len));
					check_field("char_start", 21'(want.char_start), 21'(got.char_start));
					check_field("char_number", 21'(want.char_number), 21'(got.char_number));
					check_field("is_end", 21'(want.is_end), 21'(got.is_end));
					check_field("bad_lead", 21'(want.bad_lead), 21'(got.bad_lead));
					check_field("truncated", 21'(want.truncated), 21'(got.truncated));
					check_field("final_char_start", 21'(want.final_char_start),
						21'(got.final_char_start));
					if (want.is_end) begin
						n_ends++;
					end
				end
			end
			n_waiting = expected_q.size();
		end
	end

endmodule

// ----- verif/tb.sv -----
// Top of the decoder testbench: clock, reset, byte and result traffic, and the verdict.
module tb import u8sd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int {
		CH_ASCII,
		CH_TWO,
		CH_THREE,
		CH_FOUR,
		CH_BAD
	} char_kind_t;

	localparam int unsigned PHASE_BYTES = 400;
	localparam int unsigned LONG_CHARS = 150;
	localparam int unsigned HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;

	u8sd_byte_if in_ch();
	u8sd_result_if out_ch();

	int unsigned fail_count;
	int unsigned waiting;
	int unsigned results_seen;
	int unsigned ends_seen;

	int unsigned idle_pct;
	int unsigned stall_pct;
	bit hold_req;
	bit hold_taken;
	int unsigned hold_left;
	int unsigned bytes_sent;
	int unsigned strings_sent;

	utf8_stream_decoder_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	u8sd_decode_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_mon(in_ch),
		.out_mon(out_ch),
		.fail_count(fail_count),
		.waiting(waiting),
		.results_seen(results_seen),
		.ends_seen(ends_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		out_ch.ready = 1'b0;
		hold_left = 0;
		hold_taken = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		do @(posedge clk); while (!in_ch.ready);
		bytes_sent++;
	endtask

	function automatic logic [7:0] cont_byte();
		if ($urandom_range(4) == 0) begin
			return 8'($urandom_range(1, 255));
		end
		return {2'b10, 6'($urandom)};
	endfunction

	function automatic char_kind_t random_kind(input int unsigned ascii_pct);
		if ($urandom_range(99) < ascii_pct) begin
			return CH_ASCII;
		end
		return char_kind_t'($urandom_range(int'(CH_TWO), int'(CH_BAD)));
	endfunction

	// A cut character stops somewhere before its last continuation byte.
	task automatic send_char(input char_kind_t kind, input bit cut);
		int unsigned n_cont;
		n_cont = 0;
		case (kind)
			CH_ASCII: send_byte(8'($urandom_range(1, 127)));
			CH_TWO: begin
				send_byte(LEAD2_TAG | 8'($urandom_range(31)));
				n_cont = 1;
			end
			CH_THREE: begin
				send_byte(LEAD3_TAG | 8'($urandom_range(15)));
				n_cont = 2;
			end
			CH_FOUR: begin
				send_byte(LEAD4_TAG | 8'($urandom_range(7)));
				n_cont = 3;
			end
			default: begin
				if ($urandom_range(1) == 0) begin
					send_byte(8'($urandom_range(8'h80, 8'hBF)));
				end else begin
					send_byte(8'($urandom_range(8'hF8, 8'hFF)));
				end
			end
		endcase
		if (cut && n_cont > 0) begin
			n_cont = $urandom_range(n_cont - 1);
		end
		repeat (n_cont) send_byte(cont_byte());
	endtask

	task automatic send_string(input int unsigned n_chars, input bit cut, input bit noisy,
			input int unsigned ascii_pct);
		repeat (n_chars) begin
			if (noisy && $urandom_range(7) == 0) begin
				send_byte(8'($urandom_range(1, 255)));
			end else begin
				send_char(random_kind(ascii_pct), 1'b0);
			end
		end
		if (cut) begin
			send_char(char_kind_t'($urandom_range(int'(CH_TWO), int'(CH_FOUR))), 1'b1);
		end
		send_byte(8'h00);
		strings_sent++;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [7:0] opening [];
		int unsigned phase_idle [4];
		int unsigned phase_stall [4];
		int unsigned phase_end;

		opening = '{8'h00, 8'h41, 8'h7F, 8'h00, 8'hC2, 8'hA9, 8'hE2, 8'h82,
			8'hAC, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hC0, 8'h80, 8'h80, 8'hFF, 8'hF8, 8'h00,
			8'hE2, 8'h82, 8'h00, 8'hF0, 8'h00, 8'hC3, 8'h00};
		phase_idle = '{0, 72, 0, 7};
		phase_stall = '{0, 0, 72, 7};
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = 8'h00;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		bytes_sent = 0;
		strings_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Empty, plain, multi-byte, bad-lead and cut strings first.
		foreach (opening[i]) begin
			send_byte(opening[i]);
		end
		drain();

		// Two longer strings, the first one ending in a cut character.
		send_string(LONG_CHARS, 1'b1, 1'b0, 90);
		send_string(LONG_CHARS, 1'b0, 1'b0, 90);
		drain();

		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			if (p == 0) begin
				hold_req = 1'b1;
			end
			phase_end = bytes_sent + PHASE_BYTES;
			while (bytes_sent < phase_end) begin
				if ($urandom_range(9) == 0) begin
					send_byte(8'($urandom_range(255)));
				end else begin
					send_string($urandom_range(10), $urandom_range(6) == 0,
						$urandom_range(4) == 0, 40);
				end
			end
			drain();
		end

		repeat (8) @(posedge clk);
		$display("Sent %0d requests in %0d strings, including two longer strings.",
			bytes_sent, strings_sent);
		$display("Checked %0d results, %0d of them end results, under four idle mixes.",
			results_seen, ends_seen);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+src
src/u8sd_pkg.sv
src/u8sd_channels.sv
src/u8sd_front.sv
src/u8sd_queue.sv
src/u8sd_back.sv
src/utf8_stream_decoder_unit.sv
verif/u8sd_decode_checker.sv
verif/tb.sv
